FILE: hdl/mfbp_pkg.sv
// Package for the MSB-first bit packer: mode codes, payload structs and the
// command record that travels from the front end to the back end.
// No dependencies.
package mfbp_pkg;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 6;
    localparam int PAYLOAD_W = 40;
    localparam int BUF_W     = 48;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [2:0] MODE_FIELD  = 3'd0;
    localparam logic [2:0] MODE_BYTE   = 3'd1;
    localparam logic [2:0] MODE_U16    = 3'd2;
    localparam logic [2:0] MODE_U32    = 3'd3;
    localparam logic [2:0] MODE_VARINT = 3'd4;
    localparam logic [2:0] MODE_FLUSH  = 3'd5;

    localparam logic [COUNT_W-1:0] MAX_FIELD_BITS = 6'd32;

    typedef struct packed {
        logic [2:0]         mode;
        logic [DATA_W-1:0]  data_value;
        logic [COUNT_W-1:0] bit_count;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // Bits to append MSB-first, left-aligned in payload, zero below count.
    typedef struct packed {
        logic                 align;
        logic [COUNT_W-1:0]   count;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } cmd_push_t;

endpackage

FILE: hdl/mfbp_front.sv
// Front end of the bit packer: turns one input item into a command record.
// Depends on mfbp_pkg.
module mfbp_front (
    input  mfbp_pkg::item_t     item,
    input  logic                accept,
    output mfbp_pkg::cmd_push_t push_out
);

    logic [mfbp_pkg::COUNT_W-1:0]   cnt;
    logic [32:0]                    mask33;
    logic [mfbp_pkg::DATA_W-1:0]    masked;
    logic [mfbp_pkg::PAYLOAD_W-1:0] field_payload;
    logic [mfbp_pkg::PAYLOAD_W-1:0] varint_payload;
    logic [2:0]                     vbytes;
    logic [7:0]                     vb0, vb1, vb2, vb3, vb4;
    logic [31:0]                    d;

    assign d = item.data_value;

    always_comb
    begin
        cnt = (item.bit_count > mfbp_pkg::MAX_FIELD_BITS) ? mfbp_pkg::MAX_FIELD_BITS
                                                         : item.bit_count;
        mask33 = (33'd1 << cnt) - 33'd1;
        masked = d & mask33[31:0];
        field_payload = {masked, 8'd0} << (mfbp_pkg::MAX_FIELD_BITS - cnt);
    end

    // LEB128: seven bits per byte, continuation flag on all but the last byte.
    always_comb
    begin
        if (d[31:28] != 4'd0)
            vbytes = 3'd5;
        else if (d[27:21] != 7'd0)
            vbytes = 3'd4;
        else if (d[20:14] != 7'd0)
            vbytes = 3'd3;
        else if (d[13:7] != 7'd0)
            vbytes = 3'd2;
        else
            vbytes = 3'd1;
        vb0 = {(vbytes > 3'd1), d[6:0]};
        vb1 = {(vbytes > 3'd2), d[13:7]};
        vb2 = {(vbytes > 3'd3), d[20:14]};
        vb3 = {(vbytes > 3'd4), d[27:21]};
        vb4 = {4'd0, d[31:28]};
        varint_payload = {vb0, vb1, vb2, vb3, vb4};
    end

    always_comb
    begin
        push_out.push        = 1'b0;
        push_out.cmd.align   = 1'b1;
        push_out.cmd.count   = '0;
        push_out.cmd.payload = '0;
        case (item.mode)
            mfbp_pkg::MODE_FIELD:
            begin
                push_out.push        = accept && (cnt != '0);
                push_out.cmd.align   = 1'b0;
                push_out.cmd.count   = cnt;
                push_out.cmd.payload = field_payload;
            end
            mfbp_pkg::MODE_BYTE:
            begin
                push_out.push        = accept;
                push_out.cmd.count   = 6'd8;
                push_out.cmd.payload = {d[7:0], 32'd0};
            end
            mfbp_pkg::MODE_U16:
            begin
                push_out.push        = accept;
                push_out.cmd.count   = 6'd16;
                push_out.cmd.payload = {d[7:0], d[15:8], 24'd0};
            end
            mfbp_pkg::MODE_U32:
            begin
                push_out.push        = accept;
                push_out.cmd.count   = 6'd32;
                push_out.cmd.payload = {d[7:0], d[15:8], d[23:16], d[31:24], 8'd0};
            end
            mfbp_pkg::MODE_VARINT:
            begin
                push_out.push        = accept;
                push_out.cmd.count   = {vbytes, 3'd0};
                push_out.cmd.payload = varint_payload;
            end
            mfbp_pkg::MODE_FLUSH:
            begin
                push_out.push = accept;
            end
            default:
            begin
                push_out.push = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/mfbp_cmd_fifo.sv
// Short command queue between the front end and the back end of the packer.
// Depends on mfbp_pkg.
module mfbp_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  mfbp_pkg::cmd_push_t push_in,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output mfbp_pkg::cmd_t      head
);

    mfbp_pkg::cmd_t                mem_reg [mfbp_pkg::FIFO_DEPTH];
    logic [mfbp_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mfbp_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mfbp_pkg::FIFO_AW:0]    level_reg, level_next;
    logic                          do_pop;

    assign full       = (level_reg == (mfbp_pkg::FIFO_AW+1)'(mfbp_pkg::FIFO_DEPTH));
    assign head_valid = (level_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push_in.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + {{mfbp_pkg::FIFO_AW{1'b0}}, push_in.push}
                                - {{mfbp_pkg::FIFO_AW{1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
            mem_reg[wr_ptr_reg] <= push_in.cmd;
    end

endmodule

FILE: hdl/mfbp_back.sv
// Back end of the packer: appends command bits to the bit buffer and sends
// completed bytes, one per cycle unless the receiver stalls, through an output register.
// Depends on mfbp_pkg.
module mfbp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  mfbp_pkg::cmd_t    head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output mfbp_pkg::result_t result_data
);

    // The top of buf_reg is the oldest bit; when idle it holds the partial
    // byte and total_reg is its fill count.
    logic [mfbp_pkg::BUF_W-1:0]   buf_reg, buf_next;
    logic [mfbp_pkg::COUNT_W-1:0] total_reg, total_next;
    logic                         active_reg, active_next;
    logic                         out_valid_reg, out_valid_next;
    mfbp_pkg::result_t            out_reg, out_next;

    logic                         can_emit, emit, finishing, done;
    logic [mfbp_pkg::BUF_W-1:0]   buf_a;
    logic [mfbp_pkg::COUNT_W-1:0] total_a;
    logic [3:0]                   offset;

    always_comb
    begin
        can_emit  = !out_valid_reg || !result_stall;
        emit      = active_reg && can_emit;
        finishing = emit && (total_reg < 6'd16);
        done      = !active_reg || finishing;
        pop       = done && head_valid;

        buf_a   = emit ? (buf_reg << 8) : buf_reg;
        total_a = emit ? (total_reg - 6'd8) : total_reg;

        // A byte-wide write pads any partial byte out to a whole byte first.
        if (head.align)
            offset = (total_a[2:0] != 3'd0) ? 4'd8 : 4'd0;
        else
            offset = {1'b0, total_a[2:0]};

        if (pop)
        begin
            buf_next    = {buf_a[mfbp_pkg::BUF_W-1 -: 8], {(mfbp_pkg::BUF_W-8){1'b0}}}
                        | ({head.payload, 8'd0} >> offset);
            total_next  = {2'd0, offset} + head.count;
            active_next = (total_next >= 6'd8);
        end
        else
        begin
            buf_next    = buf_a;
            total_next  = total_a;
            active_next = active_reg && !finishing;
        end

        out_next.out_byte = buf_reg[mfbp_pkg::BUF_W-1 -: 8];
        out_next.last     = (total_reg < 6'd16);
        if (emit)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            total_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (total_reg < 6'd8))
        else $error("idle back end holds a full byte");

    a_active_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (total_reg >= 6'd8))
        else $error("active back end has no complete byte");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (buf_reg[mfbp_pkg::BUF_W-9:0] == '0))
        else $error("stale bits below the partial byte");

    a_no_emit_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> !($past(emit)))
        else $error("byte emitted into a stalled output register");

endmodule

FILE: hdl/msb_first_bit_packer.sv
// MSB-first bit packer: an accepted item passes through the command queue, the
// back end's bit buffer and the output register before its first result byte
// appears. The next command loads in the cycle of the previous command's final
// byte, so the bytes of back-to-back byte-wide writes follow with no gap unless the receiver stalls.
// Reset clears the partial byte, fill count, command queue and output valid flag.
// Depends on mfbp_pkg, mfbp_front, mfbp_cmd_fifo and mfbp_back.
module msb_first_bit_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mfbp_pkg::item_t   item_data,
    output logic              result_valid,
    input  logic              result_stall,
    output mfbp_pkg::result_t result_data
);

    mfbp_pkg::cmd_push_t push;
    mfbp_pkg::cmd_t      head;
    logic                head_valid;
    logic                pop;
    logic                full;
    logic                accept;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    mfbp_front u_front (
        .item     (item_data),
        .accept   (accept),
        .push_out (push)
    );

    mfbp_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_in    (push),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    mfbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

FILE: dv/tb_msb_first_bit_packer.sv
// Self-checking testbench for msb_first_bit_packer: a scoreboard predicts each
// packed byte and its last flag, and random valid/stall traffic drives both sides.
// Depends on mfbp_pkg and the msb_first_bit_packer RTL.
module tb_msb_first_bit_packer;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int RANDOM_ITEMS = 371;
    localparam int QUIET_ITEMS  = 80;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_ITEMS   = 24;
    localparam int CYCLE_LIMIT  = 400000;

    class packed_byte_scoreboard;
        logic [7:0]        partial_bits;
        logic [2:0]        bits_held;
        mfbp_pkg::result_t expected_bytes[$];
        int                mismatches;

        function new();
            partial_bits = 8'h00;
            bits_held = 3'd0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_byte(logic [7:0] b);
            mfbp_pkg::result_t r;
            r.out_byte = b;
            r.last = 1'b0;
            expected_bytes.push_back(r);
        endfunction

        function void pad_partial();
            if (bits_held != 3'd0)
            begin
                push_byte(partial_bits);
                partial_bits = 8'h00;
                bits_held = 3'd0;
            end
        endfunction

        function void append_bits(logic [31:0] v, int n);
            for (int k = n - 1; k >= 0; k--)
            begin
                partial_bits[3'd7 - bits_held] = v[k];
                if (bits_held == 3'd7)
                begin
                    push_byte(partial_bits);
                    partial_bits = 8'h00;
                    bits_held = 3'd0;
                end
                else
                    bits_held = bits_held + 3'd1;
            end
        endfunction

        function void write_byte(logic [7:0] b);
            pad_partial();
            push_byte(b);
        endfunction

        function void note_item(mfbp_pkg::item_t it);
            int                queued;
            int                n;
            logic [31:0]       v;
            logic [7:0]        b;
            mfbp_pkg::result_t r;
            queued = expected_bytes.size();
            case (it.mode)
                mfbp_pkg::MODE_FIELD:
                begin
                    n = (it.bit_count > mfbp_pkg::MAX_FIELD_BITS)
                        ? int'(mfbp_pkg::MAX_FIELD_BITS) : int'(it.bit_count);
                    append_bits(it.data_value, n);
                end
                mfbp_pkg::MODE_BYTE:
                    write_byte(it.data_value[7:0]);
                mfbp_pkg::MODE_U16:
                begin
                    write_byte(it.data_value[7:0]);
                    write_byte(it.data_value[15:8]);
                end
                mfbp_pkg::MODE_U32:
                begin
                    write_byte(it.data_value[7:0]);
                    write_byte(it.data_value[15:8]);
                    write_byte(it.data_value[23:16]);
                    write_byte(it.data_value[31:24]);
                end
                mfbp_pkg::MODE_VARINT:
                begin
                    v = it.data_value;
                    do
                    begin
                        b = {1'b0, v[6:0]};
                        v = v >> 7;
                        if (v != 32'd0)
                            b[7] = 1'b1;
                        write_byte(b);
                    end
                    while (v != 32'd0);
                end
                mfbp_pkg::MODE_FLUSH:
                    pad_partial();
                default:
                    ;
            endcase
            if (expected_bytes.size() > queued)
            begin
                r = expected_bytes.pop_back();
                r.last = 1'b1;
                expected_bytes.push_back(r);
            end
        endfunction

        function void check_byte(mfbp_pkg::result_t got);
            mfbp_pkg::result_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: expected none, got %02h (last %0b)", got.out_byte, got.last);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    mfbp_pkg::item_t   item_data;
    logic              result_valid;
    logic              result_stall;
    mfbp_pkg::result_t result_data;

    packed_byte_scoreboard sb = new();
    int send_gap_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    msb_first_bit_packer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(item_data);
        if (rst_n && result_valid && !result_stall)
            sb.check_byte(result_data);
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("msb_first_bit_packer regression: fail");
        $finish;
    end

    function automatic mfbp_pkg::item_t make_item(logic [2:0] m, logic [31:0] d,
                                                  logic [5:0] n);
        mfbp_pkg::item_t it;
        it.mode = m;
        it.data_value = d;
        it.bit_count = n;
        return it;
    endfunction

    function automatic mfbp_pkg::item_t random_item();
        mfbp_pkg::item_t it;
        int              pick;
        pick = $urandom_range(0, 99);
        it.data_value = $urandom;
        it.bit_count = 6'($urandom_range(0, 63));
        if (pick < 40)
        begin
            it.mode = mfbp_pkg::MODE_FIELD;
            it.bit_count = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                       : 6'($urandom_range(0, 32));
        end
        else if (pick < 50)
            it.mode = mfbp_pkg::MODE_BYTE;
        else if (pick < 60)
            it.mode = mfbp_pkg::MODE_U16;
        else if (pick < 70)
            it.mode = mfbp_pkg::MODE_U32;
        else if (pick < 85)
        begin
            it.mode = mfbp_pkg::MODE_VARINT;
            it.data_value = it.data_value >> $urandom_range(0, 32);
        end
        else if (pick < 95)
            it.mode = mfbp_pkg::MODE_FLUSH;
        else
            it.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
        return it;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_item(mfbp_pkg::item_t it);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data <= it;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'hffff_ffff, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'h0000_0001, 6'd1));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'h0000_0005, 6'd3));
        send_item(make_item(mfbp_pkg::MODE_FLUSH, 32'hffff_ffff, 6'd63));
        send_item(make_item(mfbp_pkg::MODE_FLUSH, 32'h0000_0000, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'hffff_ffff, 6'd32));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'ha5a5_a5a5, 6'd63));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'h0000_0003, 6'd5));
        send_item(make_item(mfbp_pkg::MODE_BYTE, 32'h0000_00ff, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_U16, 32'h1234_abcd, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'h0000_0001, 6'd1));
        send_item(make_item(mfbp_pkg::MODE_U32, 32'hffff_ffff, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_VARINT, 32'h0000_0000, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_VARINT, 32'hffff_ffff, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'h0000_0000, 6'd7));
        // Pending bits plus a five-byte varint gives the largest burst of bytes.
        send_item(make_item(mfbp_pkg::MODE_VARINT, 32'h8000_0000, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_VARINT, 32'h0000_007f, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_VARINT, 32'h0000_0080, 6'd0));
        send_item(make_item(MODE_SPARE6, 32'h1234_5678, 6'd8));
        send_item(make_item(MODE_SPARE7, 32'hffff_ffff, 6'd63));
        send_item(make_item(mfbp_pkg::MODE_U32, 32'h0000_0000, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'h0000_0000, 6'd32));
        send_item(make_item(mfbp_pkg::MODE_FIELD, 32'hffff_ffff, 6'd40));
        send_item(make_item(mfbp_pkg::MODE_BYTE, 32'h0000_0000, 6'd0));
        send_item(make_item(mfbp_pkg::MODE_FLUSH, 32'h0000_0000, 6'd0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
            begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            else if (i < RANDOM_ITEMS - QUIET_ITEMS && i % 30 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 15;
                    default: send_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end

            if (i == 150)
            begin
                // Long receiver hold-off while back-to-back 32-bit writes fill the block.
                hold_req = 1'b1;
                send_gap_pct = 0;
                for (int j = 0; j < HOLD_ITEMS; j++)
                    send_item(make_item(mfbp_pkg::MODE_U32, $urandom,
                                        6'($urandom_range(0, 63))));
            end
            if (i == 300)
                drain_results();

            send_item(random_item());
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (sb.mismatches == 0)
            $display("msb_first_bit_packer regression: pass");
        else
            $display("msb_first_bit_packer regression: fail");
        $finish;
    end
endmodule

FILE: msb_first_bit_packer.f
hdl/mfbp_pkg.sv
hdl/mfbp_front.sv
hdl/mfbp_cmd_fifo.sv
hdl/mfbp_back.sv
hdl/msb_first_bit_packer.sv
dv/tb_msb_first_bit_packer.sv
